/* hw/rtl/grid_divergence_stencil_top_defines.svh */
// Assertion macros for the checker file of the divergence stencil.
// Depends on nothing; each macro expects signal clk in scope, the first two also rst.
`ifndef GRID_DIVERGENCE_STENCIL_TOP_DEFINES_SVH
`define GRID_DIVERGENCE_STENCIL_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define GDS_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("stencil check failed");

// Next-cycle implication, ignored while reset is high.
`define GDS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("stencil check failed");

// Next-cycle implication that also covers reset itself.
`define GDS_ASSERT_ALWAYS_NEXT(label, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("stencil check failed");

`endif

/* hw/rtl/gds_pkg.sv */
// Shared types and constants of the divergence stencil.
// Depends on nothing; every other file of the block but the defines header imports it.
package gds_pkg;

  localparam int CODE_W     = 8;
  localparam int VEL_W      = 32;
  localparam int IDX_W      = 6;
  localparam int CFG_SIZE_W = 7;
  localparam int CFG_ADDR_W = 5;
  localparam int APB_W      = 32;
  localparam int TERM_W     = VEL_W + 1;
  localparam int SUM_W      = VEL_W + 4;

  localparam int MAX_I_DEF = 64;
  localparam int MAX_J_DEF = 64;
  localparam int MAX_K_DEF = 64;

  localparam logic [CFG_SIZE_W-1:0] SIZE_RST      = 7'd64;
  localparam logic [VEL_W-1:0]      INV_WIDTH_RST = 32'h0001_0000;
  localparam logic [CODE_W-1:0]     FULL_CODE_RST = 8'sd1;
  localparam logic [CODE_W-1:0]     NULL_CODE_RST = 8'hFF;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SIZE_I    = 3'd0,
    REG_SIZE_J    = 3'd1,
    REG_SIZE_K    = 3'd2,
    REG_INV_WIDTH = 3'd3,
    REG_FULL_CODE = 3'd4,
    REG_NULL_CODE = 3'd5
  } reg_idx_t;

  // One stored cell: boundary code and velocity.
  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic signed [VEL_W-1:0]  vz;
  } cell_t;

  // Control bits that travel with each pipeline slot.
  typedef struct packed {
    logic valid;
    logic emit;
    logic done;
  } ctl_t;

  // Position of the emitted cell.
  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } idx_t;

endpackage

/* hw/rtl/grid_divergence_stencil_top.sv */
// After acceptance of the completing cell, a result goes through the stage 0 to stage 4 registers.
// Throughput: one cell per cycle unless a result is held; each stage and store read port takes one.
// A result is due for each interior cell, once the cell above it in k arrives.
// Reset (rst, synchronous) clears pipeline valids and raster position and loads register defaults.
// The plane stores are not cleared; no clearing pass runs after reset.
module grid_divergence_stencil_top #(
  parameter int MAX_I = gds_pkg::MAX_I_DEF,
  parameter int MAX_J = gds_pkg::MAX_J_DEF,
  parameter int MAX_K = gds_pkg::MAX_K_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gds_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [gds_pkg::APB_W-1:0]            pwdata,
  output logic [gds_pkg::APB_W-1:0]            prdata,
  output logic                                 pready,
  input  logic                                 cell_valid,
  output logic                                 cell_stall,
  input  logic                                 first_cell,
  input  logic signed [gds_pkg::CODE_W-1:0]    cell_code,
  input  logic signed [gds_pkg::VEL_W-1:0]     vel_x,
  input  logic signed [gds_pkg::VEL_W-1:0]     vel_y,
  input  logic signed [gds_pkg::VEL_W-1:0]     vel_z,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [gds_pkg::VEL_W-1:0]     divergence,
  output logic [gds_pkg::IDX_W-1:0]            cell_i,
  output logic [gds_pkg::IDX_W-1:0]            cell_j,
  output logic [gds_pkg::IDX_W-1:0]            cell_k,
  output logic                                 grid_done
);
  import gds_pkg::*;

  localparam int AW = 1 + $clog2(MAX_J) + $clog2(MAX_I);

  logic [CFG_SIZE_W-1:0] size_i, size_j, size_k;
  logic [VEL_W-1:0]      inv_cell_width;
  logic signed [CODE_W-1:0] full_code, null_code;
  reg_idx_t              reg_sel;
  logic                  en;
  logic                  accept;
  cell_t                 cell_in;

  ctl_t           ctl0, ctl1, ctl2;
  idx_t           idx0, idx1, idx2, idx_out;
  cell_t          cell0, zp1;
  logic [AW-1:0]  addr_w, addr_c, addr_ip, addr_im, addr_jp, addr_jm;
  cell_t          rd_c, rd_zm, rd_xp, rd_xm, rd_yp, rd_ym;
  logic signed [SUM_W-1:0] sum2;

  // The whole pipeline advances unless a finished request is held.
  assign en         = !(result_valid && result_stall);
  assign cell_stall = !en;
  assign accept     = cell_valid && en;
  assign cell_in    = '{code: cell_code, vx: vel_x, vy: vel_y, vz: vel_z};

  // Configuration registers on the APB-style port.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_i         <= SIZE_RST;
      size_j         <= SIZE_RST;
      size_k         <= SIZE_RST;
      inv_cell_width <= INV_WIDTH_RST;
      full_code      <= FULL_CODE_RST;
      null_code      <= NULL_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_SIZE_I:    size_i         <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_J:    size_j         <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_K:    size_k         <= pwdata[CFG_SIZE_W-1:0];
        REG_INV_WIDTH: inv_cell_width <= pwdata;
        REG_FULL_CODE: full_code      <= pwdata[CODE_W-1:0];
        REG_NULL_CODE: null_code      <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_SIZE_I:    prdata = APB_W'(size_i);
      REG_SIZE_J:    prdata = APB_W'(size_j);
      REG_SIZE_K:    prdata = APB_W'(size_k);
      REG_INV_WIDTH: prdata = inv_cell_width;
      REG_FULL_CODE: prdata = APB_W'(full_code);
      REG_NULL_CODE: prdata = APB_W'(null_code);
      default:       prdata = '0;
    endcase
  end

  // Stage 0: raster position and store addresses.
  gds_raster #(
    .MAX_I (MAX_I),
    .MAX_J (MAX_J),
    .MAX_K (MAX_K),
    .AW    (AW)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .accept     (accept),
    .first_cell (first_cell),
    .cell_in    (cell_in),
    .size_i     (size_i),
    .size_j     (size_j),
    .size_k     (size_k),
    .ctl        (ctl0),
    .idx        (idx0),
    .cell_out   (cell0),
    .addr_w     (addr_w),
    .addr_c     (addr_c),
    .addr_ip    (addr_ip),
    .addr_im    (addr_im),
    .addr_jp    (addr_jp),
    .addr_jm    (addr_jm)
  );

  // Stage 1: three identical store copies give six reads per cycle while the pipeline advances.
  gds_plane_mem #(.AW (AW)) u_mem_cz (
    .clk     (clk),
    .en      (en),
    .we      (ctl0.valid),
    .waddr   (addr_w),
    .wdata   (cell0),
    .raddr_a (addr_c),
    .raddr_b (addr_w),
    .rdata_a (rd_c),
    .rdata_b (rd_zm)
  );

  gds_plane_mem #(.AW (AW)) u_mem_x (
    .clk     (clk),
    .en      (en),
    .we      (ctl0.valid),
    .waddr   (addr_w),
    .wdata   (cell0),
    .raddr_a (addr_ip),
    .raddr_b (addr_im),
    .rdata_a (rd_xp),
    .rdata_b (rd_xm)
  );

  gds_plane_mem #(.AW (AW)) u_mem_y (
    .clk     (clk),
    .en      (en),
    .we      (ctl0.valid),
    .waddr   (addr_w),
    .wdata   (cell0),
    .raddr_a (addr_jp),
    .raddr_b (addr_jm),
    .rdata_a (rd_yp),
    .rdata_b (rd_ym)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (en) begin
      ctl1 <= ctl0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= idx0;
      zp1  <= cell0;
    end
  end

  // Stage 2: neighbour terms and sum.
  gds_stencil u_stencil (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ctl1),
    .idx_in    (idx1),
    .centre    (rd_c),
    .xp        (rd_xp),
    .xm        (rd_xm),
    .yp        (rd_yp),
    .ym        (rd_ym),
    .zp        (zp1),
    .zm        (rd_zm),
    .full_code (full_code),
    .null_code (null_code),
    .ctl       (ctl2),
    .idx       (idx2),
    .sum       (sum2)
  );

  // Stages 3 and 4: scaling and the output register.
  gds_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .ctl_in         (ctl2),
    .idx_in         (idx2),
    .sum            (sum2),
    .inv_cell_width (inv_cell_width),
    .valid          (result_valid),
    .divergence     (divergence),
    .idx            (idx_out),
    .done           (grid_done)
  );

  assign cell_i = idx_out.i;
  assign cell_j = idx_out.j;
  assign cell_k = idx_out.k;

endmodule

/* hw/rtl/gds_raster.sv */
// Raster position tracking, interior test and plane store addresses (stage 0).
// Depends on gds_pkg.
module gds_raster #(
  parameter int MAX_I = gds_pkg::MAX_I_DEF,
  parameter int MAX_J = gds_pkg::MAX_J_DEF,
  parameter int MAX_K = gds_pkg::MAX_K_DEF,
  parameter int AW    = 1 + $clog2(MAX_J) + $clog2(MAX_I)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                accept,
  input  logic                                first_cell,
  input  gds_pkg::cell_t                      cell_in,
  input  logic [gds_pkg::CFG_SIZE_W-1:0]      size_i,
  input  logic [gds_pkg::CFG_SIZE_W-1:0]      size_j,
  input  logic [gds_pkg::CFG_SIZE_W-1:0]      size_k,
  output gds_pkg::ctl_t                       ctl,
  output gds_pkg::idx_t                       idx,
  output gds_pkg::cell_t                      cell_out,
  output logic [AW-1:0]                       addr_w,
  output logic [AW-1:0]                       addr_c,
  output logic [AW-1:0]                       addr_ip,
  output logic [AW-1:0]                       addr_im,
  output logic [AW-1:0]                       addr_jp,
  output logic [AW-1:0]                       addr_jm
);
  import gds_pkg::*;

  localparam int IW  = $clog2(MAX_I);
  localparam int JW  = $clog2(MAX_J);
  localparam int KW  = $clog2(MAX_K);
  localparam int SIW = ($clog2(MAX_I + 1) > CFG_SIZE_W) ? $clog2(MAX_I + 1) : CFG_SIZE_W;
  localparam int SJW = ($clog2(MAX_J + 1) > CFG_SIZE_W) ? $clog2(MAX_J + 1) : CFG_SIZE_W;
  localparam int SKW = ($clog2(MAX_K + 1) > CFG_SIZE_W) ? $clog2(MAX_K + 1) : CFG_SIZE_W;

  logic [IW-1:0] pos_i, pos_i_next;
  logic [JW-1:0] pos_j, pos_j_next;
  logic [KW-1:0] pos_k, pos_k_next;

  logic [SIW-1:0] si, ni;
  logic [SJW-1:0] sj, nj;
  logic [SKW-1:0] sk, nk;
  logic [IW-1:0]  pi;
  logic [JW-1:0]  pj;
  logic [KW-1:0]  pk;
  logic           interior;
  logic           last;

  // Effective sizes: clamped to three and to the largest grid.
  always_comb begin
    si = SIW'(size_i);
    sj = SJW'(size_j);
    sk = SKW'(size_k);
    if (si < SIW'(3)) si = SIW'(3);
    else if (si > SIW'(MAX_I)) si = SIW'(MAX_I);
    if (sj < SJW'(3)) sj = SJW'(3);
    else if (sj > SJW'(MAX_J)) sj = SJW'(MAX_J);
    if (sk < SKW'(3)) sk = SKW'(3);
    else if (sk > SKW'(MAX_K)) sk = SKW'(MAX_K);
  end

  // Position of this cell, interior test and the advance to the next cell.
  always_comb begin
    pi = first_cell ? '0 : pos_i;
    pj = first_cell ? '0 : pos_j;
    pk = first_cell ? '0 : pos_k;

    interior = (SKW'(pk) >= SKW'(2)) && (SKW'(pk) <= sk - SKW'(1)) &&
               (SIW'(pi) >= SIW'(1)) && (SIW'(pi) <= si - SIW'(2)) &&
               (SJW'(pj) >= SJW'(1)) && (SJW'(pj) <= sj - SJW'(2));
    last = (SIW'(pi) == si - SIW'(2)) && (SJW'(pj) == sj - SJW'(2)) &&
           (SKW'(pk) == sk - SKW'(1));

    ni = SIW'(pi) + SIW'(1);
    nj = SJW'(pj);
    nk = SKW'(pk);
    if (ni >= si) begin
      ni = '0;
      nj = SJW'(pj) + SJW'(1);
      if (nj >= sj) begin
        nj = '0;
        nk = SKW'(pk) + SKW'(1);
        if (nk >= sk) nk = '0;
      end
    end
    pos_i_next = IW'(ni);
    pos_j_next = JW'(nj);
    pos_k_next = KW'(nk);
  end

  // Raster position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_i <= '0;
      pos_j <= '0;
      pos_k <= '0;
    end else if (accept) begin
      pos_i <= pos_i_next;
      pos_j <= pos_j_next;
      pos_k <= pos_k_next;
    end
  end

  // Stage 0 control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= accept;
      ctl.emit  <= interior;
      ctl.done  <= last;
    end
  end

  // Stage 0 payload: the cell, its indices and the store addresses.
  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_in;
      idx.i    <= IDX_W'(pi);
      idx.j    <= IDX_W'(pj);
      idx.k    <= IDX_W'(pk - KW'(1));
      addr_w   <= {pk[0], pj, pi};
      addr_c   <= {~pk[0], pj, pi};
      addr_ip  <= {~pk[0], pj, IW'(pi + IW'(1))};
      addr_im  <= {~pk[0], pj, IW'(pi - IW'(1))};
      addr_jp  <= {~pk[0], JW'(pj + JW'(1)), pi};
      addr_jm  <= {~pk[0], JW'(pj - JW'(1)), pi};
    end
  end

endmodule

/* hw/rtl/gds_plane_mem.sv */
// Two-plane cell store copy: one write port, two registered read ports.
// Depends on gds_pkg.
module gds_plane_mem #(
  parameter int AW = 13
) (
  input  logic           clk,
  input  logic           en,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  gds_pkg::cell_t wdata,
  input  logic [AW-1:0]  raddr_a,
  input  logic [AW-1:0]  raddr_b,
  output gds_pkg::cell_t rdata_a,
  output gds_pkg::cell_t rdata_b
);
  import gds_pkg::*;

  cell_t mem [2**AW];

  // Reads return the old contents when the write hits the same entry.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[waddr] <= wdata;
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hw/rtl/gds_stencil.sv */
// Neighbour term selection and the six-term sum of one cell (stage 2).
// Depends on gds_pkg.
module gds_stencil (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  gds_pkg::ctl_t                   ctl_in,
  input  gds_pkg::idx_t                   idx_in,
  input  gds_pkg::cell_t                  centre,
  input  gds_pkg::cell_t                  xp,
  input  gds_pkg::cell_t                  xm,
  input  gds_pkg::cell_t                  yp,
  input  gds_pkg::cell_t                  ym,
  input  gds_pkg::cell_t                  zp,
  input  gds_pkg::cell_t                  zm,
  input  logic signed [gds_pkg::CODE_W-1:0] full_code,
  input  logic signed [gds_pkg::CODE_W-1:0] null_code,
  output gds_pkg::ctl_t                   ctl,
  output gds_pkg::idx_t                   idx,
  output logic signed [gds_pkg::SUM_W-1:0] sum
);
  import gds_pkg::*;

  // Contribution of one neighbour; hi selects the upper side.
  function automatic logic signed [TERM_W-1:0] term(
    input logic signed [CODE_W-1:0] code,
    input logic signed [VEL_W-1:0]  nv,
    input logic signed [VEL_W-1:0]  cv,
    input logic                     hi,
    input logic signed [CODE_W-1:0] nc
  );
    logic signed [TERM_W-1:0] n;
    logic signed [TERM_W-1:0] c;
    begin
      n = TERM_W'(nv);
      c = TERM_W'(cv);
      if (!code[CODE_W-1]) term = hi ? n : -n;
      else if (code == nc) term = hi ? c : -c;
      else term = c[TERM_W-1] ? c : -c;
    end
  endfunction

  logic signed [TERM_W-1:0] t_xp, t_xm, t_yp, t_ym, t_zp, t_zm;
  logic signed [SUM_W-1:0]  sum_next;

  // Terms and sum; a cell that is not fluid gives zero.
  always_comb begin
    t_xp = term(xp.code, xp.vx, centre.vx, 1'b1, null_code);
    t_xm = term(xm.code, xm.vx, centre.vx, 1'b0, null_code);
    t_yp = term(yp.code, yp.vy, centre.vy, 1'b1, null_code);
    t_ym = term(ym.code, ym.vy, centre.vy, 1'b0, null_code);
    t_zp = term(zp.code, zp.vz, centre.vz, 1'b1, null_code);
    t_zm = term(zm.code, zm.vz, centre.vz, 1'b0, null_code);
    sum_next = (SUM_W'(t_xp) + SUM_W'(t_xm)) + (SUM_W'(t_yp) + SUM_W'(t_ym)) +
               (SUM_W'(t_zp) + SUM_W'(t_zm));
    if (centre.code != full_code) sum_next = '0;
  end

  // Stage 2 control: only interior cells stay valid from here on.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid & ctl_in.emit;
      ctl.emit  <= ctl_in.emit;
      ctl.done  <= ctl_in.done;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (en) begin
      idx <= idx_in;
      sum <= sum_next;
    end
  end

endmodule

/* hw/rtl/gds_scale.sv */
// Scaling by half the inverse cell width with rounding and saturation (stages 3, 4).
// Depends on gds_pkg.
module gds_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  gds_pkg::ctl_t                    ctl_in,
  input  gds_pkg::idx_t                    idx_in,
  input  logic signed [gds_pkg::SUM_W-1:0] sum,
  input  logic [gds_pkg::VEL_W-1:0]        inv_cell_width,
  output logic                             valid,
  output logic signed [gds_pkg::VEL_W-1:0] divergence,
  output gds_pkg::idx_t                    idx,
  output logic                             done
);
  import gds_pkg::*;

  localparam int HI_W = SUM_W - 1 - VEL_W;
  localparam int R_W  = HI_W + 2 * VEL_W - 17 + 4;

  logic [SUM_W-1:0]        mag;
  logic                    neg3;
  logic [2*VEL_W-1:0]      plo;
  logic [HI_W+VEL_W-1:0]   phi;
  ctl_t                    ctl3;
  idx_t                    idx3;
  logic [R_W-1:0]          r;
  logic signed [VEL_W-1:0] div_next;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // Stage 3: magnitude split into a 32-bit low part and three high bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (en) begin
      ctl3 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx3 <= idx_in;
      neg3 <= sum[SUM_W-1];
      plo  <= mag[VEL_W-1:0] * inv_cell_width;
      phi  <= mag[SUM_W-2:VEL_W] * inv_cell_width;
    end
  end

  // Round to nearest on the magnitude, then apply the sign and saturate.
  always_comb begin
    r = R_W'((plo + (2*VEL_W)'(65536)) >> 17) + (R_W'(phi) << 15);
    if (neg3) begin
      if (r >= R_W'(33'h0_8000_0000)) div_next = 32'sh8000_0000;
      else div_next = VEL_W'(-r);
    end else begin
      if (r > R_W'(32'h7FFF_FFFF)) div_next = 32'sh7FFF_FFFF;
      else div_next = VEL_W'(r);
    end
  end

  // Stage 4: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divergence <= div_next;
      idx        <= idx3;
      done       <= ctl3.done;
    end
  end

endmodule

/* hw/rtl/gds_checker.sv */
// Port-level checks of the divergence stencil, bound to the top level.
// Depends on gds_pkg and grid_divergence_stencil_top_defines.svh.
`include "grid_divergence_stencil_top_defines.svh"

module gds_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cell_valid,
  input logic                                 cell_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [gds_pkg::VEL_W-1:0]     divergence,
  input logic                                 grid_done
);
  import gds_pkg::*;

  // Input back-pressure only comes from a held result request.
  `GDS_ASSERT_NOW(a_stall_cause, cell_stall, result_valid && result_stall)
  // A held result request stays.
  `GDS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)
  // A held result request keeps its payload.
  `GDS_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(divergence) && $stable(grid_done))
  // Reset empties the pipeline.
  `GDS_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !result_valid && !cell_stall)

endmodule

bind grid_divergence_stencil_top gds_checker u_gds_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the streaming 3D divergence stencil.
// Depends on gds_pkg and grid_divergence_stencil_top; predicts each result itself.
`timescale 1ns / 1ps

module testbench;
  import gds_pkg::*;

  localparam int PLANE_DEPTH = 2 * MAX_I_DEF * MAX_J_DEF;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;
  logic cell_valid = 1'b0;
  logic cell_stall;
  logic first_cell = 1'b0;
  logic signed [CODE_W-1:0] cell_code = '0;
  logic signed [VEL_W-1:0] vel_x = '0;
  logic signed [VEL_W-1:0] vel_y = '0;
  logic signed [VEL_W-1:0] vel_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [VEL_W-1:0] divergence;
  logic [IDX_W-1:0] cell_i;
  logic [IDX_W-1:0] cell_j;
  logic [IDX_W-1:0] cell_k;
  logic grid_done;

  typedef struct {
    logic [VEL_W-1:0] div;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic done;
  } div_result_t;

  div_result_t pending_div[$];
  int errors = 0;
  int cells_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow copy of the registers, the plane store and the raster position.
  logic [6:0] m_size_i = SIZE_RST, m_size_j = SIZE_RST, m_size_k = SIZE_RST;
  logic [31:0] m_inv = INV_WIDTH_RST;
  logic signed [7:0] m_full = FULL_CODE_RST, m_null = NULL_CODE_RST;
  logic signed [7:0] pl_code[PLANE_DEPTH];
  logic signed [31:0] pl_vx[PLANE_DEPTH], pl_vy[PLANE_DEPTH], pl_vz[PLANE_DEPTH];
  int unsigned at_i = 0, at_j = 0, at_k = 0;

  grid_divergence_stencil_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int unsigned clamp_size(logic [6:0] s);
    if (s < 3) return 3;
    if (s > 64) return 64;
    return s;
  endfunction

  function automatic int unsigned plane_slot(int unsigned p, int unsigned i, int unsigned j);
    return (((p & 1) * MAX_J_DEF + (j % MAX_J_DEF)) * MAX_I_DEF + (i % MAX_I_DEF));
  endfunction

  // Contribution of one neighbour to the difference sum.
  function automatic longint face_term(logic signed [7:0] code, logic signed [31:0] nv,
                                       logic signed [31:0] cv, bit hi_side);
    longint c;
    c = cv;
    if (code >= 0) return hi_side ? longint'(nv) : -longint'(nv);
    if (code == m_null) return hi_side ? c : -c;
    return (c < 0) ? c : -c;
  endfunction

  // Multiply by half the inverse width, round half away from zero, saturate.
  function automatic logic [31:0] scale_saturate(longint d);
    bit neg;
    longint unsigned mag, lo, hi, r;
    neg = d < 0;
    mag = neg ? longint'(-d) : d;
    lo = mag & 64'hFFFF_FFFF;
    hi = mag >> 32;
    r = ((lo * m_inv + 65536) >> 17) + ((hi * m_inv) << 15);
    if (neg) begin
      if (r >= 64'h8000_0000) return 32'h8000_0000;
      return 32'h0 - r[31:0];
    end
    if (r > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return r[31:0];
  endfunction

  // Advance the shadow state by one accepted cell and queue any due result.
  task automatic predict_divergence(bit first, logic signed [7:0] code,
                                    logic signed [31:0] vx, logic signed [31:0] vy,
                                    logic signed [31:0] vz);
    int unsigned si, sj, sk, cp, c, d, e, w;
    longint s;
    div_result_t r;
    si = clamp_size(m_size_i);
    sj = clamp_size(m_size_j);
    sk = clamp_size(m_size_k);
    if (first) begin
      at_i = 0;
      at_j = 0;
      at_k = 0;
    end
    if (at_k >= 2 && at_k <= sk - 1 && at_i >= 1 && at_i <= si - 2 &&
        at_j >= 1 && at_j <= sj - 2) begin
      cp = at_k - 1;
      c = plane_slot(cp, at_i, at_j);
      d = plane_slot(at_k, at_i, at_j);
      r.div = '0;
      if (pl_code[c] == m_full) begin
        s = 0;
        e = plane_slot(cp, at_i + 1, at_j);
        s += face_term(pl_code[e], pl_vx[e], pl_vx[c], 1'b1);
        e = plane_slot(cp, at_i - 1, at_j);
        s += face_term(pl_code[e], pl_vx[e], pl_vx[c], 1'b0);
        e = plane_slot(cp, at_i, at_j + 1);
        s += face_term(pl_code[e], pl_vy[e], pl_vy[c], 1'b1);
        e = plane_slot(cp, at_i, at_j - 1);
        s += face_term(pl_code[e], pl_vy[e], pl_vy[c], 1'b0);
        s += face_term(code, vz, pl_vz[c], 1'b1);
        s += face_term(pl_code[d], pl_vz[d], pl_vz[c], 1'b0);
        r.div = scale_saturate(s);
      end
      r.i = at_i[5:0];
      r.j = at_j[5:0];
      r.k = cp[5:0];
      r.done = (at_i == si - 2 && at_j == sj - 2 && cp == sk - 2);
      pending_div.push_back(r);
    end
    w = plane_slot(at_k, at_i, at_j);
    pl_code[w] = code;
    pl_vx[w] = vx;
    pl_vy[w] = vy;
    pl_vz[w] = vz;
    at_i++;
    if (at_i >= si) begin
      at_i = 0;
      at_j++;
      if (at_j >= sj) begin
        at_j = 0;
        at_k++;
        if (at_k >= sk) at_k = 0;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    div_result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending_div.size() == 0) begin
        report_mismatch("unexpected result", divergence, 32'h0);
      end else begin
        w = pending_div.pop_front();
        if (divergence !== w.div) report_mismatch("divergence", divergence, w.div);
        if (cell_i !== w.i) report_mismatch("cell_i", cell_i, w.i);
        if (cell_j !== w.j) report_mismatch("cell_j", cell_j, w.j);
        if (cell_k !== w.k) report_mismatch("cell_k", cell_k, w.k);
        if (grid_done !== w.done) report_mismatch("grid_done", grid_done, w.done);
      end
    end
  end

  // Send one cell request and wait for its acceptance.
  task automatic send_cell(bit first, logic signed [7:0] code, logic signed [31:0] vx,
                           logic signed [31:0] vy, logic signed [31:0] vz);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    first_cell <= first;
    cell_code <= code;
    vel_x <= vx;
    vel_y <= vy;
    vel_z <= vz;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    predict_divergence(first, code, vx, vy, vz);
    cells_sent++;
  endtask

  // Stop sending and let every expected result and any trailing work drain.
  task automatic wait_drained();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (pending_div.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SIZE_I:    m_size_i = value[6:0];
      REG_SIZE_J:    m_size_j = value[6:0];
      REG_SIZE_K:    m_size_k = value[6:0];
      REG_INV_WIDTH: m_inv = value;
      REG_FULL_CODE: m_full = value[7:0];
      REG_NULL_CODE: m_null = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(logic [6:0] si, logic [6:0] sj, logic [6:0] sk);
    cfg_write(REG_SIZE_I, 32'(si));
    cfg_write(REG_SIZE_J, 32'(sj));
    cfg_write(REG_SIZE_K, 32'(sk));
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly fluid cells that get a divergence, with open, solid and other codes.
  function automatic logic signed [7:0] rand_code();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return m_full;
    if (p < 65) return m_null;
    if (p < 80) return 8'(-8'sd128 + $urandom_range(127));
    return 8'($urandom_range(255));
  endfunction

  // A stream of cells; a restart may be thrown in as noise.
  task automatic send_cells(int n, bit first, int restart_pct);
    bit f;
    for (int c = 0; c < n; c++) begin
      f = (c == 0) ? first : ($urandom_range(999) < restart_pct);
      send_cell(f, rand_code(), rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  // Directed: two 3x3x3 grids, one interior cell, each neighbour kind and extreme values.
  task automatic test_directed();
    logic signed [7:0] code;
    logic signed [31:0] v;
    set_sizes(7'd3, 7'd3, 7'd3);
    cfg_write(REG_FULL_CODE, 32'h0000_0005);
    cfg_write(REG_NULL_CODE, 32'h0000_00FD);
    for (int g = 0; g < 2; g++) begin
      // The scale register may only change once the previous grid has drained.
      if (g > 0) wait_drained();
      cfg_write(REG_INV_WIDTH, g == 0 ? 32'hFFFF_FFFF : 32'h0002_8000);
      for (int c = 0; c < 27; c++) begin
        case (c)
          13: code = (g == 0) ? m_full : 8'sd4;
          14: code = 8'sd0;
          12: code = 8'sd127;
          16, 10: code = m_null;
          22: code = -8'sd128;
          4: code = 8'sd9;
          default: code = m_full;
        endcase
        v = (c % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        send_cell(c == 0, code, v, -v, (g == 0) ? v : ~v);
      end
    end
    wait_drained();
  endtask

  // Out-of-range sizes clamp to three and to the maximum.
  task automatic test_size_clamp();
    set_sizes(7'd0, 7'd1, 7'd2);
    cfg_write(REG_INV_WIDTH, 32'h0001_0000);
    cfg_write(REG_FULL_CODE, 32'h0000_0001);
    cfg_write(REG_NULL_CODE, 32'h0000_00FF);
    send_cells(27, 1'b1, 0);
    wait_drained();
    set_sizes(7'd3, 7'd127, 7'd3);
    send_cells(3 * 64 * 3, 1'b1, 0);
    wait_drained();
  endtask

  // Sizes shrunk while part-way through a grid, then streaming on by wrap-around.
  task automatic test_resize_midgrid();
    set_sizes(7'd6, 7'd5, 7'd4);
    send_cells(6 * 5 * 4 + 40, 1'b1, 0);
    wait_drained();
    set_sizes(7'd4, 7'd4, 7'd3);
    send_cells(4 * 4 * 3 * 2, 1'b0, 0);
    wait_drained();
  endtask

  // Random grids under random settings; consecutive grids rely on wrap-around.
  task automatic test_random_grids(int target);
    int n, grids;
    while (cells_sent < target) begin
      set_sizes(7'($urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 8)),
                7'($urandom_range(3, 6)), 7'($urandom_range(3, 5)));
      case ($urandom_range(5))
        0: cfg_write(REG_INV_WIDTH, 32'h0);
        1: cfg_write(REG_INV_WIDTH, 32'hFFFF_FFFF);
        default: cfg_write(REG_INV_WIDTH, $urandom);
      endcase
      cfg_write(REG_FULL_CODE, $urandom_range(255));
      cfg_write(REG_NULL_CODE, $urandom_range(3) == 0 ? $urandom_range(255)
                                                       : $urandom_range(128, 255));
      n = clamp_size(m_size_i) * clamp_size(m_size_j) * clamp_size(m_size_k);
      grids = $urandom_range(1, 2);
      for (int g = 0; g < grids; g++) begin
        send_cells(n / 2, g == 0, 8);
        // Hold off once per phase until every expected result has arrived.
        if (g == 0) begin
          cell_valid <= 1'b0;
          @(posedge clk);
          while (pending_div.size() != 0) @(posedge clk);
        end
        send_cells(n - n / 2, 1'b0, 8);
      end
      wait_drained();
    end
  endtask

  initial begin
    for (int a = 0; a < PLANE_DEPTH; a++) begin
      pl_code[a] = '0;
      pl_vx[a] = '0;
      pl_vy[a] = '0;
      pl_vz[a] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 35;
    recv_stall_pct = 75;
    test_directed();
    test_size_clamp();
    send_idle_pct = 75;
    recv_stall_pct = 35;
    test_resize_midgrid();
    test_random_grids(cells_sent + 100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_grids(cells_sent + 100);
    wait_drained();
    if (errors == 0 && pending_div.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gds_pkg.sv
hw/rtl/gds_raster.sv
hw/rtl/gds_plane_mem.sv
hw/rtl/gds_stencil.sv
hw/rtl/gds_scale.sv
hw/rtl/grid_divergence_stencil_top.sv
hw/rtl/gds_checker.sv
tb/testbench.sv
